>>> hw/rtl/priority_bitmap_task_scheduler_top_defines.svh
// Assertion macros used by the scheduler core RTL.
// No dependencies.
`ifndef PRIORITY_BITMAP_TASK_SCHEDULER_TOP_DEFINES_SVH
`define PRIORITY_BITMAP_TASK_SCHEDULER_TOP_DEFINES_SVH
// implication checked on each rising clock edge outside reset
`define PBTS_ASSERT_IMP(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error(msg);
// next-cycle implication
`define PBTS_ASSERT_NXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error(msg);
`endif

>>> hw/rtl/pbts_pkg.sv
// Package for the priority bitmap task scheduler: word types, request codes, states.
// No dependencies.
package pbts_pkg;
    localparam int PRIO_LEVELS_DEF = 32;
    localparam int TASK_SLOTS_DEF  = 16;
    localparam logic [7:0] LOCK_MAX = 8'd255;
    localparam logic [7:0] SLICE_RESET = 8'd10;

    typedef enum logic [2:0] {
        REQ_READY     = 3'd0,
        REQ_NOT_READY = 3'd1,
        REQ_DELAY     = 3'd2,
        REQ_WAKE      = 3'd3,
        REQ_TICK      = 3'd4,
        REQ_LOCK      = 3'd5,
        REQ_UNLOCK    = 3'd6,
        REQ_SCHEDULE  = 3'd7
    } t_req;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [3:0]  task_id;
        logic [4:0]  task_priority;
        logic [31:0] tick_count;
    } t_in_word;

    typedef struct packed {
        logic        switch_request;
        logic [3:0]  chosen_task;
        logic        none_ready;
        logic [7:0]  lock_level;
    } t_out_word;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_TICK_SCAN,
        ST_SLICE,
        ST_ROT_DEQ,
        ST_ROT_ENQ,
        ST_PRI_SCAN,
        ST_PICK,
        ST_DONE
    } t_state;
endpackage

>>> hw/rtl/pbts_core.sv
// Sequenced scheduler core: queues, delay counters, slices and one shared decrementer.
// Depends on pbts_pkg and the assertion macro header.
`include "priority_bitmap_task_scheduler_top_defines.svh"
module pbts_core import pbts_pkg::*; #(
    parameter int PRIORITY_LEVELS = PRIO_LEVELS_DEF,
    parameter int TASK_SLOTS      = TASK_SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_in_word  i_word,
    input  logic [7:0] i_slice_length,
    output logic      o_busy,
    output logic      o_done,
    output t_out_word o_word
);
    localparam int TW = $clog2(TASK_SLOTS + 1);
    localparam int TI = $clog2(TASK_SLOTS);
    localparam int PW = $clog2(PRIORITY_LEVELS);
    localparam logic [TW-1:0] NIL = TW'(TASK_SLOTS);

    t_state r_state, n_state;
    t_in_word r_req;
    logic [PRIORITY_LEVELS-1:0] r_bitmap;
    logic [TW-1:0] r_head [PRIORITY_LEVELS];
    logic [TW-1:0] r_tail [PRIORITY_LEVELS];
    logic [TW-1:0] r_lnext [TASK_SLOTS];
    logic [TW-1:0] r_lprev [TASK_SLOTS];
    logic [PW-1:0] r_prio [TASK_SLOTS];
    logic [TASK_SLOTS-1:0] r_queued, r_delayed;
    logic [31:0] r_dcount [TASK_SLOTS];
    logic [7:0] r_slice [TASK_SLOTS];
    logic [TW-1:0] r_running;
    logic [7:0] r_lock;
    logic [TW-1:0] r_idx;
    logic [PW:0] r_pidx;
    logic [TW-1:0] r_rot;
    logic r_sw;
    logic [3:0] r_next;

    // shared decrementer over the scanned counter
    logic [TI-1:0] idx;
    logic [31:0] dec_in, dec_out;
    assign idx = r_idx[TI-1:0];
    assign dec_in = r_dcount[idx];
    assign dec_out = (dec_in != 32'd0) ? dec_in - 32'd1 : 32'd0;

    logic [PW-1:0] req_p;
    logic task_ok;
    assign task_ok = {28'd0, r_req.task_id} < 32'(TASK_SLOTS);
    assign req_p = ({27'd0, r_req.task_priority} >= 32'(PRIORITY_LEVELS)) ?
                   PW'(PRIORITY_LEVELS - 1) : PW'(r_req.task_priority);

    logic [TI-1:0] run_i;
    logic [PW-1:0] run_p;
    assign run_i = r_running[TI-1:0];
    assign run_p = r_prio[run_i];

    logic [PW-1:0] pix;
    assign pix = r_pidx[PW-1:0];

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE:      if (i_start) n_state = ST_DISPATCH;
            ST_DISPATCH: begin
                case (t_req'(r_req.req_type))
                    REQ_TICK:     n_state = ST_TICK_SCAN;
                    REQ_SCHEDULE: n_state = ST_PRI_SCAN;
                    REQ_UNLOCK:   n_state = (r_lock == 8'd1) ? ST_PRI_SCAN : ST_DONE;
                    default:      n_state = ST_DONE;
                endcase
            end
            ST_TICK_SCAN: if (r_idx == TW'(TASK_SLOTS - 1)) n_state = ST_SLICE;
            ST_SLICE: begin
                if (r_running == NIL || r_slice[run_i] > 8'd1) n_state = ST_PRI_SCAN;
                else if (r_head[run_p] != NIL && r_head[run_p] != r_tail[run_p])
                    n_state = ST_ROT_DEQ;
                else n_state = ST_PRI_SCAN;
            end
            ST_ROT_DEQ:   n_state = ST_ROT_ENQ;
            ST_ROT_ENQ:   n_state = ST_PRI_SCAN;
            ST_PRI_SCAN: begin
                if (r_lock != 8'd0 || r_bitmap == '0) n_state = ST_DONE;
                else if (r_bitmap[pix]) n_state = ST_PICK;
            end
            ST_PICK:      n_state = ST_DONE;
            ST_DONE:      n_state = ST_IDLE;
            default:      n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_busy = (r_state != ST_IDLE);
        o_done = (r_state == ST_DONE);
        o_word.switch_request = r_sw;
        o_word.chosen_task = r_next;
        o_word.none_ready = (r_bitmap == '0);
        o_word.lock_level = r_lock;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_bitmap <= '0;
            r_queued <= '0;
            r_delayed <= '0;
            r_running <= NIL;
            r_lock <= 8'd0;
            r_idx <= '0;
            r_pidx <= '0;
            r_sw <= 1'b0;
            r_next <= 4'd0;
            for (int i = 0; i < PRIORITY_LEVELS; i++) begin
                r_head[i] <= NIL;
                r_tail[i] <= NIL;
            end
            for (int i = 0; i < TASK_SLOTS; i++) begin
                r_slice[i] <= SLICE_RESET;
                r_prio[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_req <= i_word;
                        r_sw <= 1'b0;
                        r_next <= 4'd0;
                        r_idx <= '0;
                        r_pidx <= '0;
                    end
                end
                ST_DISPATCH: begin
                    case (t_req'(r_req.req_type))
                        REQ_READY: if (task_ok && !r_queued[r_req.task_id[TI-1:0]]) begin
                            r_lnext[r_req.task_id[TI-1:0]] <= NIL;
                            r_lprev[r_req.task_id[TI-1:0]] <= r_tail[req_p];
                            if (r_tail[req_p] == NIL) r_head[req_p] <= TW'(r_req.task_id);
                            else r_lnext[r_tail[req_p][TI-1:0]] <= TW'(r_req.task_id);
                            r_tail[req_p] <= TW'(r_req.task_id);
                            r_prio[r_req.task_id[TI-1:0]] <= req_p;
                            r_queued[r_req.task_id[TI-1:0]] <= 1'b1;
                            r_bitmap[req_p] <= 1'b1;
                        end
                        REQ_NOT_READY: if (task_ok && r_queued[r_req.task_id[TI-1:0]]) begin
                            r_rot <= TW'(r_req.task_id);
                            r_queued[r_req.task_id[TI-1:0]] <= 1'b0;
                            begin : deq
                                logic [TI-1:0] t;
                                logic [PW-1:0] p;
                                logic [TW-1:0] nx, pv;
                                t = r_req.task_id[TI-1:0];
                                p = r_prio[t];
                                nx = r_lnext[t];
                                pv = r_lprev[t];
                                if (pv == NIL) r_head[p] <= nx;
                                else r_lnext[pv[TI-1:0]] <= nx;
                                if (nx == NIL) r_tail[p] <= pv;
                                else r_lprev[nx[TI-1:0]] <= pv;
                                if (pv == NIL && nx == NIL) r_bitmap[p] <= 1'b0;
                            end
                        end
                        REQ_DELAY: if (task_ok) begin
                            r_dcount[r_req.task_id[TI-1:0]] <= r_req.tick_count;
                            r_delayed[r_req.task_id[TI-1:0]] <= 1'b1;
                        end
                        REQ_WAKE: if (task_ok) r_delayed[r_req.task_id[TI-1:0]] <= 1'b0;
                        REQ_LOCK: if (r_lock != LOCK_MAX) r_lock <= r_lock + 8'd1;
                        REQ_UNLOCK: if (r_lock != 8'd0) r_lock <= r_lock - 8'd1;
                        default: ;
                    endcase
                end
                ST_TICK_SCAN: begin
                    r_idx <= r_idx + TW'(1);
                    if (r_delayed[idx]) begin
                        r_dcount[idx] <= dec_out;
                        if (dec_out == 32'd0) begin
                            r_delayed[idx] <= 1'b0;
                            if (!r_queued[idx]) begin : enq
                                logic [PW-1:0] p;
                                p = r_prio[idx];
                                r_lnext[idx] <= NIL;
                                r_lprev[idx] <= r_tail[p];
                                if (r_tail[p] == NIL) r_head[p] <= r_idx;
                                else r_lnext[r_tail[p][TI-1:0]] <= r_idx;
                                r_tail[p] <= r_idx;
                                r_queued[idx] <= 1'b1;
                                r_bitmap[p] <= 1'b1;
                            end
                        end
                    end
                end
                ST_SLICE: begin
                    if (r_running != NIL) begin
                        if (r_slice[run_i] > 8'd1) r_slice[run_i] <= r_slice[run_i] - 8'd1;
                        else r_slice[run_i] <= i_slice_length;
                    end
                    r_rot <= r_head[run_p];
                end
                ST_ROT_DEQ: begin
                    // head leaves: its successor becomes head (queue has two or more)
                    r_head[run_p] <= r_lnext[r_rot[TI-1:0]];
                    r_lprev[r_lnext[r_rot[TI-1:0]][TI-1:0]] <= NIL;
                end
                ST_ROT_ENQ: begin
                    r_lnext[r_rot[TI-1:0]] <= NIL;
                    r_lprev[r_rot[TI-1:0]] <= r_tail[run_p];
                    r_lnext[r_tail[run_p][TI-1:0]] <= r_rot;
                    r_tail[run_p] <= r_rot;
                end
                ST_PRI_SCAN: if (!r_bitmap[pix]) r_pidx <= r_pidx + (PW+1)'(1);
                ST_PICK: begin
                    if (r_head[pix] != NIL && r_head[pix] != r_running) begin
                        r_running <= r_head[pix];
                        r_sw <= 1'b1;
                        r_next <= 4'(r_head[pix]);
                    end
                end
                default: ;
            endcase
        end
    end

    `PBTS_ASSERT_IMP(a_done_from_work, i_clk, i_rst_n, o_done, $past(r_state) != ST_IDLE, "stray done")
    `PBTS_ASSERT_IMP(a_sw_unlocked, i_clk, i_rst_n, o_done && r_sw, r_lock == 8'd0, "locked switch")
    `PBTS_ASSERT_NXT(a_done_idle, i_clk, i_rst_n, o_done, r_state == ST_IDLE, "done not idle")
endmodule

>>> hw/rtl/pbts_out_reg.sv
// Output holding register: keeps one result word until the consumer takes it or a new word is loaded.
// Depends on pbts_pkg.
module pbts_out_reg import pbts_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_load,
    input  t_out_word i_word,
    input  logic      i_ready,
    output logic      o_valid,
    output logic      o_full,
    output t_out_word o_word
);
    logic r_valid;
    t_out_word r_word;
    assign o_valid = r_valid;
    assign o_full = r_valid && !i_ready;
    assign o_word = r_word;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            if (i_load) r_valid <= 1'b1;
            else if (i_ready) r_valid <= 1'b0;
        end
        if (i_load) r_word <= i_word;
    end
endmodule

>>> hw/rtl/priority_bitmap_task_scheduler_top.sv
// Top level of the priority bitmap task scheduler.
// Depends on pbts_pkg, pbts_core and pbts_out_reg.
// One request at a time: ready, not-ready, delay, wake and lock go from dispatch straight
// to done; schedule, and an unlock that brings the lock level to zero, add the bitmap scan
// and pick; a tick steps through the delay counters (one delay counter per cycle through
// the shared decrementer), then the slice check and, when the slice has run out and the
// queue holds two or more, the rotation, then the schedule scan. Ready drops while a
// request is in work and while an untaken result would be overwritten.
module priority_bitmap_task_scheduler_top import pbts_pkg::*; #(
    parameter int PRIORITY_LEVELS = PRIO_LEVELS_DEF,
    parameter int TASK_SLOTS      = TASK_SLOTS_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [7:0] i_cfg_data,
    input  logic       i_valid,
    output logic       o_ready,
    input  t_in_word   i_word,
    output logic       o_valid,
    input  logic       i_ready,
    output t_out_word  o_word
);
    logic [7:0] r_slice_length;
    logic busy, done, full;
    t_out_word core_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_slice_length <= SLICE_RESET;
        else if (i_cfg_we) r_slice_length <= i_cfg_data;
    end

    assign o_ready = !busy && !full;

    pbts_core #(.PRIORITY_LEVELS(PRIORITY_LEVELS), .TASK_SLOTS(TASK_SLOTS)) u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_valid && o_ready),
        .i_word(i_word), .i_slice_length(r_slice_length),
        .o_busy(busy), .o_done(done), .o_word(core_word)
    );

    pbts_out_reg u_out (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_load(done), .i_word(core_word),
        .i_ready(i_ready), .o_valid(o_valid), .o_full(full), .o_word(o_word)
    );
endmodule

>>> verif/tb_priority_bitmap_task_scheduler_top.sv
// Testbench for priority_bitmap_task_scheduler_top: drives request words, predicts each
// response word with a behavioral scheduler model and compares the whole word, printing the fields on a mismatch.
// Depends on pbts_pkg and the scheduler RTL.
`timescale 1ns / 1ps

module tb_priority_bitmap_task_scheduler_top import pbts_pkg::*; ();

    localparam int NLVL = 32;
    localparam int NTASK = 16;
    localparam logic [4:0] NO_TASK = 5'd16;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int DRAIN_CYCLES = 120;

    logic i_clk = 0;
    logic i_rst_n = 0;
    logic i_cfg_we = 0;
    logic [7:0] i_cfg_data = '0;
    logic i_valid = 0;
    logic o_ready;
    t_in_word i_word = '0;
    logic o_valid;
    logic i_ready = 0;
    t_out_word o_word;

    priority_bitmap_task_scheduler_top uut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data),
        .i_valid(i_valid), .o_ready(o_ready), .i_word(i_word),
        .o_valid(o_valid), .i_ready(i_ready), .o_word(o_word)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // scheduler shadow state
    logic [7:0] m_slice_len;
    logic [31:0] m_bitmap;
    logic [4:0] m_head [NLVL];
    logic [4:0] m_tail [NLVL];
    logic [4:0] m_next [NTASK];
    logic [4:0] m_prev [NTASK];
    logic [4:0] m_prio [NTASK];
    logic m_queued [NTASK];
    logic m_delayed [NTASK];
    logic [31:0] m_count [NTASK];
    logic [7:0] m_slice [NTASK];
    logic [4:0] m_running;
    logic [7:0] m_lock;

    t_out_word expected_q[$];
    int errors = 0;
    int mismatches = 0;
    int words_sent = 0;
    int words_checked = 0;
    int switches_seen = 0;
    longint cycles = 0;
    bit hold_off = 0;

    function automatic void model_reset();
        m_slice_len = SLICE_RESET;
        m_bitmap = '0;
        for (int i = 0; i < NLVL; i++) begin
            m_head[i] = NO_TASK;
            m_tail[i] = NO_TASK;
        end
        for (int i = 0; i < NTASK; i++) begin
            m_next[i] = NO_TASK;
            m_prev[i] = NO_TASK;
            m_prio[i] = '0;
            m_queued[i] = 0;
            m_delayed[i] = 0;
            m_count[i] = '0;
            m_slice[i] = SLICE_RESET;
        end
        m_running = NO_TASK;
        m_lock = '0;
    endfunction

    function automatic void append_task(int t, int p);
        logic [4:0] last;
        last = m_tail[p];
        if (m_queued[t]) return;
        m_next[t] = NO_TASK;
        m_prev[t] = last;
        if (last >= NTASK) m_head[p] = t[4:0];
        else m_next[last] = t[4:0];
        m_tail[p] = t[4:0];
        m_prio[t] = p[4:0];
        m_queued[t] = 1;
        m_bitmap[p] = 1'b1;
    endfunction

    function automatic void remove_task(int t);
        logic [4:0] p, n, pv;
        if (!m_queued[t]) return;
        p = m_prio[t];
        n = m_next[t];
        pv = m_prev[t];
        if (pv >= NTASK) m_head[p] = n;
        else m_next[pv] = n;
        if (n >= NTASK) m_tail[p] = pv;
        else m_prev[n] = pv;
        m_queued[t] = 0;
        if (m_head[p] >= NTASK) m_bitmap[p] = 1'b0;
    endfunction

    function automatic void pick_task(ref t_out_word r);
        int p;
        logic [4:0] pick;
        if (m_lock != 0 || m_bitmap == 0) return;
        p = 0;
        while (!m_bitmap[p]) p++;
        pick = m_head[p];
        if (pick >= NTASK || pick == m_running) return;
        m_running = pick;
        r.switch_request = 1'b1;
        r.chosen_task = pick[3:0];
    endfunction

    function automatic void tick_all(ref t_out_word r);
        logic [4:0] p, h;
        for (int t = 0; t < NTASK; t++) begin
            if (!m_delayed[t]) continue;
            if (m_count[t] > 0) m_count[t]--;
            if (m_count[t] == 0) begin
                m_delayed[t] = 0;
                append_task(t, m_prio[t]);
            end
        end
        if (m_running < NTASK) begin
            if (m_slice[m_running] > 1) begin
                m_slice[m_running]--;
            end else begin
                p = m_prio[m_running];
                h = m_head[p];
                if (h < NTASK && h != m_tail[p]) begin
                    remove_task(h);
                    append_task(h, p);
                end
                m_slice[m_running] = m_slice_len;
            end
        end
        pick_task(r);
    endfunction

    function automatic t_out_word predict_response(t_in_word w);
        t_out_word r;
        int t;
        r = '0;
        t = w.task_id;
        case (t_req'(w.req_type))
            REQ_READY:     append_task(t, w.task_priority);
            REQ_NOT_READY: remove_task(t);
            REQ_DELAY: begin
                m_count[t] = w.tick_count;
                m_delayed[t] = 1;
            end
            REQ_WAKE:      m_delayed[t] = 0;
            REQ_TICK:      tick_all(r);
            REQ_LOCK:      if (m_lock < LOCK_MAX) m_lock++;
            REQ_UNLOCK: begin
                if (m_lock > 0) begin
                    m_lock--;
                    if (m_lock == 0) pick_task(r);
                end
            end
            default:       pick_task(r);
        endcase
        r.none_ready = (m_bitmap == 0);
        r.lock_level = m_lock;
        return r;
    endfunction

    // watchdog
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver: own stall pattern, plus long hold-off when requested
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_off) begin
            i_ready <= 1'b0;
        end else begin
            case (cycles[9:8])
                2'd0: i_ready <= 1'b1;
                2'd1: i_ready <= ($urandom_range(0, 3) != 0);
                2'd2: i_ready <= ($urandom_range(0, 3) == 0);
                default: i_ready <= cycles[2];
            endcase
        end
    end

    // response checker
    always @(posedge i_clk) begin
        t_out_word e;
        if (i_rst_n && o_valid && i_ready) begin
            words_checked++;
            if (expected_q.size() == 0) begin
                errors++;
                $display("unexpected response word %h", o_word);
            end else begin
                e = expected_q.pop_front();
                if (e.switch_request) switches_seen++;
                if (o_word !== e) begin
                    errors++;
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: exp sw=%0d nt=%0d nr=%0d lk=%0d, %s",
                            e.switch_request, e.chosen_task, e.none_ready,
                            e.lock_level, "got:");
                    if (mismatches <= 10)
                        $display("          got sw=%0d nt=%0d nr=%0d lk=%0d",
                            o_word.switch_request, o_word.chosen_task,
                            o_word.none_ready, o_word.lock_level);
                end
            end
        end
    end

    // send one request word; valid stays up for a following word, a gap or a drain drops it
    task automatic send_word(t_req rq, int t, int p, logic [31:0] d);
        t_in_word w;
        w.req_type = rq;
        w.task_id = t[3:0];
        w.task_priority = p[4:0];
        w.tick_count = d;
        i_valid <= 1'b1;
        i_word <= w;
        @(posedge i_clk);
        while (!o_ready) @(posedge i_clk);
        expected_q.push_back(predict_response(w));
        words_sent++;
    endtask

    task automatic random_gap();
        if ($urandom_range(0, 5) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_slice(logic [7:0] v);
        wait_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        m_slice_len = v;
    endtask

    // random request word, weighted toward tick and ready requests and toward priorities 0 to 3
    task automatic send_random();
        int r;
        t_req rq;
        logic [31:0] d;
        r = $urandom_range(0, 99);
        if (r < 22) rq = REQ_READY;
        else if (r < 32) rq = REQ_NOT_READY;
        else if (r < 42) rq = REQ_DELAY;
        else if (r < 47) rq = REQ_WAKE;
        else if (r < 75) rq = REQ_TICK;
        else if (r < 81) rq = REQ_LOCK;
        else if (r < 88) rq = REQ_UNLOCK;
        else rq = REQ_SCHEDULE;
        case ($urandom_range(0, 9))
            0: d = $urandom();
            1: d = 32'hFFFF_FFFF;
            2: d = 0;
            default: d = $urandom_range(1, 6);
        endcase
        send_word(rq, $urandom_range(0, 15),
            ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 3), d);
    endtask

    task automatic test_directed();
        send_word(REQ_SCHEDULE, 0, 0, 0);          // empty bitmap
        send_word(REQ_TICK, 0, 0, 0);              // no running task
        send_word(REQ_UNLOCK, 0, 0, 0);            // unlock at zero
        send_word(REQ_READY, 15, 31, 0);
        send_word(REQ_READY, 0, 0, 32'hFFFF_FFFF);
        send_word(REQ_READY, 0, 5, 0);             // already queued
        send_word(REQ_READY, 3, 0, 0);
        send_word(REQ_SCHEDULE, 0, 0, 0);
        send_word(REQ_SCHEDULE, 0, 0, 0);          // same task, no switch
        send_word(REQ_LOCK, 0, 0, 0);
        send_word(REQ_TICK, 0, 0, 0);              // locked
        send_word(REQ_UNLOCK, 0, 0, 0);
        send_word(REQ_NOT_READY, 7, 0, 0);         // not queued
        send_word(REQ_NOT_READY, 0, 0, 0);
        send_word(REQ_DELAY, 9, 0, 0);             // zero delay readies on tick
        send_word(REQ_DELAY, 10, 0, 32'hFFFF_FFFF);
        send_word(REQ_DELAY, 10, 0, 2);            // reload
        send_word(REQ_DELAY, 11, 0, 3);
        send_word(REQ_WAKE, 11, 0, 0);
        repeat (3) send_word(REQ_TICK, 0, 0, 0);
        send_word(REQ_SCHEDULE, 0, 0, 0);
    endtask

    task automatic test_lock_saturation();
        repeat (256) send_word(REQ_LOCK, $urandom_range(0, 15), 0, $urandom());
        repeat (256) send_word(REQ_UNLOCK, $urandom_range(0, 15), 0, $urandom());
    endtask

    task automatic test_slice_rotation(logic [7:0] len);
        write_slice(len);
        for (int t = 0; t < 4; t++) send_word(REQ_READY, t, 1, 0);
        send_word(REQ_SCHEDULE, 0, 0, 0);
        repeat (12) send_word(REQ_TICK, 0, 0, 0);
        for (int t = 0; t < 4; t++) send_word(REQ_NOT_READY, t, 0, 0);
    endtask

    task automatic test_random(int n);
        while (n > 0) begin
            send_random();
            n--;
            random_gap();
        end
    endtask

    task automatic test_backpressure();
        hold_off = 1;
        fork
            begin
                repeat (300) @(posedge i_clk);
                hold_off = 0;
            end
            repeat (8) send_random();
        join
        wait_drained();
        test_random(30);
    endtask

    initial begin
        model_reset();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_lock_saturation();
        test_slice_rotation(8'd1);
        test_slice_rotation(8'd0);
        test_slice_rotation(8'd255);
        test_slice_rotation(8'd3);
        test_random(80);
        write_slice(8'd2);
        test_backpressure();
        test_random(70);
        write_slice(8'd10);
        test_random(40);
        wait_drained();
        $display("sent %0d request words, checked %0d responses, %0d task switches",
            words_sent, words_checked, switches_seen);
        $display("slice lengths 0,1,2,3,10,255 used; %0d mismatches", mismatches);
        if (errors == 0 && expected_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end
endmodule

>>> files.f
+incdir+hw/rtl
hw/rtl/pbts_pkg.sv
hw/rtl/pbts_core.sv
hw/rtl/pbts_out_reg.sv
hw/rtl/priority_bitmap_task_scheduler_top.sv
verif/tb_priority_bitmap_task_scheduler_top.sv
